// ===== src/gats_pkg.sv =====
// gats_pkg: shared types and constants for group_avg_threshold_sum
// request and result structs, controller states, command and status bundles
// no dependencies
`default_nettype none

package gats_pkg;

  // default buffer depth in line items
  localparam int MAX_GROUP_DEF = 64;

  // field widths
  localparam int QTY_W    = 6;
  localparam int PRICE_W  = 24;
  localparam int CODE_W   = 8;
  localparam int GSUM_W   = 30;
  localparam int GITEMS_W = 7;
  localparam int TOTAL_W  = 48;
  localparam int AVG_W    = 46;

  // divide-by-7 unit: long division of total+3, one 16-bit quotient digit per step
  localparam int DIV_W       = 64;
  localparam int DIV_DIGIT_W = 16;
  localparam int DIV_STEPS   = DIV_W / DIV_DIGIT_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
  localparam int DIVISOR     = 7;
  localparam int ROUND_ADD   = 3;
  // floor(v / 7) = (v * DIV_MAGIC) >> DIV_SHIFT, exact for v below 2^21
  localparam int DIV_MAGIC   = 1198373;  // (2^23 + 3) / 7
  localparam int DIV_SHIFT   = 23;

  // configuration register index
  localparam int CFG_IDX_W = 1;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_BRAND     = cfg_idx_t'(0);
  localparam cfg_idx_t REG_CONTAINER = cfg_idx_t'(1);

  typedef struct packed {
    logic [QTY_W-1:0]   quantity;
    logic [PRICE_W-1:0] price_cents;
    logic [CODE_W-1:0]  part_brand;
    logic [CODE_W-1:0]  part_container;
    logic               last_of_group;
    logic               last_of_query;
  } req_t;

  typedef struct packed {
    logic [GSUM_W-1:0]   group_sum_cents;
    logic [GITEMS_W-1:0] group_items;
    logic                group_matched;
    logic                group_overflow;
    logic [TOTAL_W-1:0]  total_cents;
    logic [AVG_W-1:0]    yearly_avg_cents;
    logic                final_res;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_TOTAL,
    ST_DIV_LOAD,
    ST_DIV,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // take the request into the group buffer
    logic scan_rd;    // read the next buffered item
    logic total_upd;  // fold the group sum into the running total
    logic div_load;   // start the divide by 7
    logic div_step;   // one divide step
    logic emit;       // register the result and strobe it
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic closing;    // request closes its group
    logic skip;       // group overflowed, no scan
    logic scan_last;  // last buffered item is being read
    logic pipe_busy;  // scan pipeline still holds items
    logic final_q;    // group being closed also ends the query
    logic div_last;   // final divide step
  } stat_t;

endpackage

`default_nettype wire

// ===== src/group_avg_threshold_sum.sv =====
// group_avg_threshold_sum: top level, small-quantity revenue per part group
// joins gats_ctrl (sequencer) and gats_dp (buffer, scan, total, divider)
// depends on gats_pkg
//
// usage
//   request channel: a line item request is taken at a rising edge with start high
//   and busy low. items of one part come in a row; last_of_group closes the group,
//   last_of_query closes the group and the query.
//   result channel: done is high for exactly one cycle with result valid; the
//   receiver cannot stall it, so it must take the result in that cycle.
//   config: cfg_we writes cfg_data into the register at cfg_index (0 brand, 1
//   container) at the rising edge; write only while the block is idle.
// sequencing
//   an item that does not close a group is taken while idle and leaves busy low.
//   a closing item keeps busy high while the block reads each buffered item once
//   through the single read port, drains the read / compare / add pipeline,
//   updates the total and registers the result. done shows in the first cycle
//   with busy low, in which a new request may already be taken.
//   an overflowed group skips the scan and goes straight to the total. a query
//   end adds a divider load and four 16-bit quotient digits of (total + 3) / 7.
// reset
//   rst (synchronous) clears the group, the running total and both codes;
//   the buffer memory itself is not cleared and needs no clearing pass.
`default_nettype none

module group_avg_threshold_sum #(
  parameter int MAX_GROUP = gats_pkg::MAX_GROUP_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire gats_pkg::req_t              req,
  input  wire logic                        cfg_we,
  input  wire gats_pkg::cfg_idx_t          cfg_index,
  input  wire logic [gats_pkg::CODE_W-1:0] cfg_data,
  output logic                             done,
  output gats_pkg::res_t                   result
);

  // command and status between sequencer and datapath
  gats_pkg::cmd_t  cmd;
  gats_pkg::stat_t stat;

  gats_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  gats_dp #(
    .MAX_GROUP (MAX_GROUP)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .done      (done),
    .result    (result)
  );

`ifndef SYNTHESIS
  // a result only comes out once the sequencer is back to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // the block only goes busy after taking a request
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy without a request");

  // a skipped group reports no sum
  a_ovf_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.group_overflow |-> result.group_sum_cents == '0)
    else $error("overflowed group with nonzero sum");

  // the average is only given at the end of the query
  a_avg_final: assert property (@(posedge clk) disable iff (rst)
    done && !result.final_res |-> result.yearly_avg_cents == '0)
    else $error("average outside query end");
`endif

endmodule

`default_nettype wire

// ===== src/gats_ctrl.sv =====
// gats_ctrl: sequencing state machine for group_avg_threshold_sum
// depends on gats_pkg for states, command and status structs
`default_nettype none

module gats_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire gats_pkg::stat_t stat,
  output gats_pkg::cmd_t       cmd,
  output logic                 busy
);

  gats_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gats_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      gats_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          if (stat.closing) begin
            state_next = stat.skip ? gats_pkg::ST_TOTAL : gats_pkg::ST_SCAN;
          end
        end
      end
      gats_pkg::ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.scan_last) begin
          state_next = gats_pkg::ST_FLUSH;
        end
      end
      gats_pkg::ST_FLUSH: begin
        if (!stat.pipe_busy) begin
          state_next = gats_pkg::ST_TOTAL;
        end
      end
      gats_pkg::ST_TOTAL: begin
        cmd.total_upd = 1'b1;
        state_next = stat.final_q ? gats_pkg::ST_DIV_LOAD : gats_pkg::ST_EMIT;
      end
      gats_pkg::ST_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        state_next = gats_pkg::ST_DIV;
      end
      gats_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = gats_pkg::ST_EMIT;
        end
      end
      gats_pkg::ST_EMIT: begin
        cmd.emit = 1'b1;
        state_next = gats_pkg::ST_IDLE;
      end
      default: begin
        state_next = gats_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/gats_dp.sv =====
// gats_dp: datapath for group_avg_threshold_sum
// group buffer memory, threshold scan pipeline, running total, divide-by-7 unit
// depends on gats_pkg
`default_nettype none

module gats_dp #(
  parameter int MAX_GROUP = gats_pkg::MAX_GROUP_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire gats_pkg::req_t                 req,
  input  wire logic                           cfg_we,
  input  wire gats_pkg::cfg_idx_t             cfg_index,
  input  wire logic [gats_pkg::CODE_W-1:0]    cfg_data,
  input  wire gats_pkg::cmd_t                 cmd,
  output gats_pkg::stat_t                     stat,
  output logic                                done,
  output gats_pkg::res_t                      result
);

  localparam int CNT_W  = $clog2(MAX_GROUP + 1);
  localparam int ADDR_W = $clog2(MAX_GROUP);
  localparam int QSUM_W = CNT_W + gats_pkg::QTY_W;
  localparam int Q5_W   = gats_pkg::QTY_W + 3;
  localparam int PROD_W = Q5_W + CNT_W;
  localparam int MEM_W  = gats_pkg::QTY_W + gats_pkg::PRICE_W;
  localparam int GSUM_W = gats_pkg::GSUM_W;
  localparam int TOT_W  = gats_pkg::TOTAL_W;
  localparam int DIV_W  = gats_pkg::DIV_W;
  localparam int GI_W   = gats_pkg::GITEMS_W;
  localparam int DIG_W  = gats_pkg::DIV_DIGIT_W;
  localparam int DV_W   = DIG_W + 3;
  localparam int DMP_W  = DV_W + $clog2(gats_pkg::DIV_MAGIC + 1);

  // configuration
  logic [gats_pkg::CODE_W-1:0] sel_brand;
  logic [gats_pkg::CODE_W-1:0] sel_container;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_brand     <= '0;
      sel_container <= '0;
    end else if (cfg_we) begin
      if (cfg_index == gats_pkg::REG_BRAND) begin
        sel_brand <= cfg_data;
      end
      if (cfg_index == gats_pkg::REG_CONTAINER) begin
        sel_container <= cfg_data;
      end
    end
  end

  // group state
  logic [CNT_W-1:0]  item_count;
  logic [QSUM_W-1:0] qty_sum;
  logic              overflowed;
  logic              matched;
  logic              final_q;
  logic              full;

  assign full = (item_count == CNT_W'(MAX_GROUP));

  // group buffer
  logic [MEM_W-1:0]  mem [MAX_GROUP];
  logic [ADDR_W-1:0] rd_idx;
  logic [MEM_W-1:0]  rd_data;
  logic              v1, v2;

  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      mem[item_count[ADDR_W-1:0]] <= {req.quantity, req.price_cents};
    end
    if (cmd.scan_rd) begin
      rd_data <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_count <= '0;
      qty_sum    <= '0;
      overflowed <= 1'b0;
    end else if (cmd.load) begin
      if (full) begin
        overflowed <= 1'b1;
      end else begin
        item_count <= item_count + CNT_W'(1);
        qty_sum    <= qty_sum + QSUM_W'(req.quantity);
      end
    end else if (cmd.emit) begin
      item_count <= '0;
      qty_sum    <= '0;
      overflowed <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      matched <= (req.part_brand == sel_brand) && (req.part_container == sel_container);
      final_q <= req.last_of_query;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
    end else if (cmd.load) begin
      rd_idx <= '0;
    end else if (cmd.scan_rd) begin
      rd_idx <= rd_idx + ADDR_W'(1);
    end
  end

  // scan pipeline: read, threshold test, accumulate
  logic [gats_pkg::QTY_W-1:0]   rd_qty;
  logic [gats_pkg::PRICE_W-1:0] rd_price;
  logic [Q5_W-1:0]              qty5;
  logic [PROD_W-1:0]            prod;
  logic                         hit;
  logic [gats_pkg::PRICE_W-1:0] hit_price;
  logic [GSUM_W-1:0]            acc;
  logic [GSUM_W:0]              acc_sum;

  assign rd_qty   = rd_data[MEM_W-1 -: gats_pkg::QTY_W];
  assign rd_price = rd_data[gats_pkg::PRICE_W-1:0];
  assign qty5     = {1'b0, rd_qty, 2'b00} + Q5_W'(rd_qty);
  assign prod     = PROD_W'(qty5) * PROD_W'(item_count);
  assign acc_sum  = {1'b0, acc} + (GSUM_W + 1)'(hit_price);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.scan_rd;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      hit       <= prod < PROD_W'(qty_sum);
      hit_price <= rd_price;
    end
    if (cmd.load) begin
      acc <= '0;
    end else if (v2 && hit) begin
      // saturates at the top of the group sum range
      acc <= acc_sum[GSUM_W] ? '1 : acc_sum[GSUM_W-1:0];
    end
  end

  // running total
  logic [TOT_W-1:0] total;
  logic [TOT_W:0]   total_sum;

  assign total_sum = {1'b0, total} + (TOT_W + 1)'(acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (cmd.total_upd && matched && !overflowed) begin
      total <= total_sum[TOT_W] ? '1 : total_sum[TOT_W-1:0];
    end else if (cmd.emit && final_q) begin
      total <= '0;
    end
  end

  // long division by 7, one 16-bit quotient digit per step; dq ends as the quotient
  // each digit comes from a reciprocal multiply of remainder and next dividend digit
  logic [DIV_W-1:0]               dq;
  logic [2:0]                     rem;
  logic [DV_W-1:0]                div_v;
  logic [DMP_W-1:0]               div_prod;
  logic [DIG_W-1:0]               div_qd;
  logic [gats_pkg::DIV_CNT_W-1:0] div_cnt;

  assign div_v    = {rem, dq[DIV_W-1 -: DIG_W]};
  assign div_prod = DMP_W'(div_v) * DMP_W'(gats_pkg::DIV_MAGIC);
  assign div_qd   = div_prod[gats_pkg::DIV_SHIFT +: DIG_W];

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dq      <= DIV_W'(total) + DIV_W'(gats_pkg::ROUND_ADD);
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      dq      <= {dq[DIV_W-DIG_W-1:0], div_qd};
      rem     <= 3'(div_v - DV_W'(div_qd) * DV_W'(gats_pkg::DIVISOR));
      div_cnt <= div_cnt + gats_pkg::DIV_CNT_W'(1);
    end
  end

  // status
  always_comb begin
    stat.closing   = req.last_of_group || req.last_of_query;
    stat.skip      = overflowed || full;
    stat.scan_last = (CNT_W'(rd_idx) + CNT_W'(1)) == item_count;
    stat.pipe_busy = v1 || v2;
    stat.final_q   = final_q;
    stat.div_last  = div_cnt == gats_pkg::DIV_CNT_W'(gats_pkg::DIV_STEPS - 1);
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.group_sum_cents  <= overflowed ? '0 : acc;
      result.group_items      <= GI_W'(item_count);
      result.group_matched    <= matched;
      result.group_overflow   <= overflowed;
      result.total_cents      <= total;
      result.yearly_avg_cents <= final_q ? dq[gats_pkg::AVG_W-1:0] : '0;
      result.final_res        <= final_q;
    end
  end

endmodule

`default_nettype wire
